// ===== rtl/rgbmono_pkg.sv =====
// Shared constants and types for the RGB565 to 1bpp framebuffer packer.
package rgbmono_pkg;

  // Panel geometry
  localparam int FB_COLS      = 1440;
  localparam int FB_ROWS      = 720;
  localparam int FB_PITCH     = (FB_COLS + 7) / 8;
  localparam int FB_BYTES     = FB_PITCH * FB_ROWS;
  localparam int FB_AW        = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
  localparam int COL_W        = $clog2(FB_COLS);
  localparam int ROW_W        = (FB_ROWS > 1) ? $clog2(FB_ROWS) : 1;

  // Luma weights, they sum to 256
  localparam logic [15:0] LUMA_WR = 16'd76;
  localparam logic [15:0] LUMA_WG = 16'd150;
  localparam logic [15:0] LUMA_WB = 16'd30;

  localparam logic [7:0] THRESH_RESET = 8'd128;
  localparam logic [7:0] BYTE_WHITE   = 8'hFF;
  localparam logic [7:0] MSB_MASK     = 8'h80;

  // Opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Result actions
  localparam logic [2:0] ACT_DROP    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_NONE    = 3'd2;
  localparam logic [2:0] ACT_PARTIAL = 3'd3;
  localparam logic [2:0] ACT_FULL    = 3'd4;

  // Front-end result for one pixel
  typedef struct packed {
    logic             on_panel;
    logic [FB_AW-1:0] addr;
    logic [7:0]       mask;
    logic             white;
    logic [ROW_W-1:0] row;
  } pix_info_t;

endpackage

// ===== rtl/rgbmono_in_if.sv =====
// Input channel: pixel and flush beats.
interface rgbmono_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pixel_color;
  logic        request_full;

  modport source (output valid, opcode, pos_x, pos_y, pixel_color, request_full,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pixel_color, request_full,
                output ready);
endinterface

// ===== rtl/rgbmono_out_if.sv =====
// Result channel: one beat per input beat.
interface rgbmono_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [16:0] byte_address;
  logic [7:0]  byte_value;
  logic [9:0]  row_first;
  logic [9:0]  row_last;

  modport source (output valid, action, byte_address, byte_value, row_first, row_last,
                  input ready);
  modport sink (input valid, action, byte_address, byte_value, row_first, row_last,
                output ready);
endinterface

// ===== rtl/rgb565_to_mono_framebuffer_packer.sv =====
// Top level: RGB565 pixel stream packed into a 1bpp framebuffer with dirty-row tracking.
//
// Usage:
//  - in_ch carries pixel beats (opcode 0) and end-of-frame flush beats (opcode 1).
//    A beat is taken at a rising edge with valid and ready high.
//  - out_ch returns exactly one result beat per input beat, in order: dropped,
//    byte written (address and new byte value), or no/partial/full refresh.
//  - cfg_wr_en/cfg_wr_data write white_threshold (reset 128); write only while idle.
//  - Throughput: one beat per clock, sustained while out_ch.ready is high, including
//    back-to-back writes to the same framebuffer byte (forwarded from the last write).
//  - Pipeline: an accepted beat passes the input register, the RAM read stage
//    and the output register before its result beat is offered on out_ch.
//  - The framebuffer lives in one single-port-read/single-port-write RAM; each
//    on-panel pixel is a read-modify-write of one byte, one per clock unless stalled.
//  - Reset: after rst_n goes high, a clearing pass writes white to all
//    FB_BYTES bytes (129600 at the default panel), one byte per cycle;
//    in_ch.ready stays low until it ends. Config writes are taken meanwhile.
//  - Stall: when out_ch.ready is low the result holds; the pipeline behind it
//    keeps filling and in_ch.ready drops only once all stages are full.
module rgb565_to_mono_framebuffer_packer import rgbmono_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  rgbmono_in_if.sink       in_ch,
  rgbmono_out_if.source    out_ch
);

  // configuration
  logic [7:0] thresh_r;

  // clearing pass
  logic             clearing_r;
  logic [FB_AW-1:0] clr_cnt_r;

  // stage A: registered input beat
  logic        a_v_r;
  logic        a_op_r;
  logic [15:0] a_x_r, a_y_r, a_color_r;
  logic        a_full_r;

  // stage B: RAM read data arrives here
  logic             b_v_r;
  logic             b_op_r;
  logic             b_full_r;
  logic             b_on_r;
  logic [FB_AW-1:0] b_addr_r;
  logic [7:0]       b_mask_r;
  logic             b_white_r;
  logic [ROW_W-1:0] b_row_r;

  // last write, for forwarding into stage B
  logic             lw_v_r;
  logic [FB_AW-1:0] lw_addr_r;
  logic [7:0]       lw_data_r;

  // dirty tracking
  logic             dirty_v_r;
  logic [ROW_W-1:0] dirty_lo_r, dirty_hi_r;
  logic             full_pend_r;

  // output register
  logic        o_v_r;
  logic [2:0]  o_act_r;
  logic [16:0] o_addr_r;
  logic [7:0]  o_byte_r;
  logic [9:0]  o_first_r, o_last_r;

  pix_info_t        pix;
  logic             ready_o, ready_b, ready_a;
  logic             adv_a, adv_b;
  logic [7:0]       ram_rd;
  logic [7:0]       b_cur, b_new;
  logic             b_wr;
  logic             flush_full;
  logic             ram_we;
  logic [FB_AW-1:0] ram_wa;
  logic [7:0]       ram_wd;

  // elastic handshake: each stage moves when the one ahead is free or moving
  assign ready_o = !o_v_r || out_ch.ready;
  assign ready_b = !b_v_r || ready_o;
  assign ready_a = !a_v_r || ready_b;
  assign adv_b   = b_v_r && ready_o;
  assign adv_a   = a_v_r && ready_b;
  assign in_ch.ready = ready_a && !clearing_r;

  rgbmono_pix_calc u_pix (
    .pos_x       (a_x_r),
    .pos_y       (a_y_r),
    .pixel_color (a_color_r),
    .threshold   (thresh_r),
    .info        (pix)
  );

  // forward the byte written at the edge of this read
  assign b_cur = (lw_v_r && (lw_addr_r == b_addr_r)) ? lw_data_r : ram_rd;
  assign b_new = b_white_r ? (b_cur | b_mask_r) : (b_cur & ~b_mask_r);
  assign b_wr  = (b_op_r == OP_PIXEL) && b_on_r;
  assign flush_full = b_full_r || full_pend_r;

  assign ram_we = clearing_r || (adv_b && b_wr);
  assign ram_wa = clearing_r ? clr_cnt_r : b_addr_r;
  assign ram_wd = clearing_r ? BYTE_WHITE : b_new;

  rgbmono_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_fb (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (adv_a),
    .rd_addr (pix.addr),
    .rd_data (ram_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      o_v_r       <= 1'b0;
      lw_v_r      <= 1'b0;
      dirty_v_r   <= 1'b0;
      dirty_lo_r  <= '0;
      dirty_hi_r  <= '0;
      full_pend_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == FB_AW'(FB_BYTES - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (ready_a) begin
        a_v_r <= in_ch.valid && !clearing_r;
      end
      if (ready_b) begin
        b_v_r <= a_v_r;
      end
      if (ready_o) begin
        o_v_r <= b_v_r;
      end
      if (adv_b && b_wr) begin
        lw_v_r <= 1'b1;
      end
      if (adv_b) begin
        if (b_op_r == OP_FLUSH) begin
          if (flush_full) begin
            full_pend_r <= 1'b0;
          end
          dirty_v_r  <= 1'b0;
          dirty_lo_r <= '0;
          dirty_hi_r <= '0;
        end else if (b_on_r) begin
          dirty_v_r <= 1'b1;
          if (!dirty_v_r || (b_row_r < dirty_lo_r)) begin
            dirty_lo_r <= b_row_r;
          end
          if (!dirty_v_r || (b_row_r > dirty_hi_r)) begin
            dirty_hi_r <= b_row_r;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      a_op_r    <= in_ch.opcode;
      a_x_r     <= in_ch.pos_x;
      a_y_r     <= in_ch.pos_y;
      a_color_r <= in_ch.pixel_color;
      a_full_r  <= in_ch.request_full;
    end
    if (adv_a) begin
      b_op_r    <= a_op_r;
      b_full_r  <= a_full_r;
      b_on_r    <= pix.on_panel;
      b_addr_r  <= pix.addr;
      b_mask_r  <= pix.mask;
      b_white_r <= pix.white;
      b_row_r   <= pix.row;
    end
    if (adv_b && b_wr) begin
      lw_addr_r <= b_addr_r;
      lw_data_r <= b_new;
    end
    if (adv_b) begin
      o_addr_r  <= '0;
      o_byte_r  <= '0;
      o_first_r <= '0;
      o_last_r  <= '0;
      if (b_op_r == OP_FLUSH) begin
        if (flush_full) begin
          o_act_r <= ACT_FULL;
        end else if (dirty_v_r) begin
          o_act_r   <= ACT_PARTIAL;
          o_first_r <= 10'(dirty_lo_r);
          o_last_r  <= 10'(dirty_hi_r);
        end else begin
          o_act_r <= ACT_NONE;
        end
      end else if (b_on_r) begin
        o_act_r  <= ACT_WRITE;
        o_addr_r <= 17'(b_addr_r);
        o_byte_r <= b_new;
      end else begin
        o_act_r <= ACT_DROP;
      end
    end
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.action       = o_act_r;
  assign out_ch.byte_address = o_addr_r;
  assign out_ch.byte_value   = o_byte_r;
  assign out_ch.row_first    = o_first_r;
  assign out_ch.row_last     = o_last_r;

endmodule

// ===== rtl/rgbmono_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module rgbmono_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read-during-write returns old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/rgbmono_pix_calc.sv =====
// Pixel front end: panel bounds, byte address, bit mask and luma threshold.
module rgbmono_pix_calc import rgbmono_pkg::*; (
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] pixel_color,
  input  logic [7:0]  threshold,
  output pix_info_t   info
);
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [4:0]       r5, b5;
  logic [5:0]       g6;
  logic [7:0]       r8, g8, b8;
  logic [15:0]      luma_sum;

  assign col = pos_x[COL_W-1:0];
  assign row = pos_y[ROW_W-1:0];

  // sign bit set means negative, then compare as unsigned
  assign info.on_panel = !pos_x[15] && !pos_y[15] &&
                         (pos_x < 16'(FB_COLS)) && (pos_y < 16'(FB_ROWS));
  assign info.addr = FB_AW'(row) * FB_AW'(FB_PITCH) + FB_AW'(col >> 3);
  assign info.mask = MSB_MASK >> col[2:0];
  assign info.row  = row;

  // channel expansion by bit replication
  assign r5 = pixel_color[15:11];
  assign g6 = pixel_color[10:5];
  assign b5 = pixel_color[4:0];
  assign r8 = {r5, r5[4:2]};
  assign g8 = {g6, g6[5:4]};
  assign b8 = {b5, b5[4:2]};

  // weights sum to 256, so the total fits 16 bits
  assign luma_sum = 16'(r8) * LUMA_WR + 16'(g8) * LUMA_WG + 16'(b8) * LUMA_WB;
  assign info.white = (luma_sum[15:8] >= threshold);
endmodule

// ===== rtl/rgbmono_checker.sv =====
// Port-level checker for the packer, attached by bind.
module rgbmono_checker import rgbmono_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_action,
  input logic [16:0] out_byte_address,
  input logic [7:0]  out_byte_value,
  input logic [9:0]  out_row_first,
  input logic [9:0]  out_row_last
);

  // reset empties the pipeline and starts the clearing pass
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("output valid or input ready right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_byte_address) && $stable(out_byte_value) &&
      $stable(out_row_first) && $stable(out_row_last))
    else $error("stalled result changed");

  // byte fields only on a write
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_WRITE) |->
      (out_byte_address == 17'd0) && (out_byte_value == 8'd0))
    else $error("byte fields set on a non-write result");

  // row fields only on a partial refresh, and ordered there
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_action == ACT_PARTIAL) ? (out_row_first <= out_row_last) :
      ((out_row_first == 10'd0) && (out_row_last == 10'd0))))
    else $error("row range fields inconsistent with action");

endmodule

bind rgb565_to_mono_framebuffer_packer rgbmono_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_action       (out_ch.action),
  .out_byte_address (out_ch.byte_address),
  .out_byte_value   (out_ch.byte_value),
  .out_row_first    (out_ch.row_first),
  .out_row_last     (out_ch.row_last)
);

// ===== sim/rgb565_to_mono_framebuffer_packer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RGB565 to 1bpp framebuffer packer.
module rgb565_to_mono_framebuffer_packer_tb;
  import rgbmono_pkg::*;

  localparam int CLK_HALF     = 10;      // 20 ns period
  localparam int RST_CYCLES   = 6;
  localparam int MAX_IDLE     = 15;      // longest gap / stall drawn per beat
  localparam int MAX_REPORTS  = 10;      // mismatches printed in full
  localparam int DRAIN_CYCLES = 8;       // quiet margin after the queue empties
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_BEATS  = 260;
  localparam int HOT_W        = 16;      // hot window: two bytes wide...
  localparam int HOT_H        = 4;       // ...and four rows tall

  // One input beat as it goes on the wire
  typedef struct {
    logic        opcode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pixel_color;
    logic        request_full;
  } pix_beat_t;

  // One result beat
  typedef struct {
    logic [2:0]  action;
    logic [16:0] byte_address;
    logic [7:0]  byte_value;
    logic [9:0]  row_first;
    logic [9:0]  row_last;
  } fb_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  rgbmono_in_if  in_ch ();
  rgbmono_out_if out_ch ();

  rgb565_to_mono_framebuffer_packer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow state of the packer: framebuffer, threshold, dirty rows
  // ---------------------------------------------------------------------
  logic [7:0] fb_shadow [FB_BYTES];
  logic [7:0] thresh_shadow;
  logic       dirty_seen;
  logic [9:0] dirty_lo;
  logic [9:0] dirty_hi;
  logic       full_owed;      // first flush after reset is always full

  fb_result_t fb_result_q[$]; // expected results, oldest first

  // Idle controls, toggled by the tests to get stretches with and without gaps
  bit tx_gap_en = 1'b1;
  bit rx_stall_en = 1'b1;

  // Random stream hot window origin
  int hot_x;
  int hot_y;

  // Run statistics
  int n_beats, n_results, n_bad;
  int n_write, n_drop, n_full, n_partial, n_none, n_cfg;

  function automatic void reset_shadow();
    foreach (fb_shadow[i]) fb_shadow[i] = BYTE_WHITE;
    thresh_shadow = THRESH_RESET;
    dirty_seen    = 1'b0;
    dirty_lo      = '0;
    dirty_hi      = '0;
    full_owed     = 1'b1;
  endfunction

  // Channels widened by bit replication, then weighted and scaled by 1/256
  function automatic int luma_of_565(logic [15:0] c);
    logic [7:0] r8, g8, b8;
    r8 = {c[15:11], c[15:13]};
    g8 = {c[10:5], c[10:9]};
    b8 = {c[4:0], c[4:2]};
    return (int'(r8) * int'(LUMA_WR) + int'(g8) * int'(LUMA_WG) +
            int'(b8) * int'(LUMA_WB)) >> 8;
  endfunction

  // Applies one accepted beat to the shadow state and returns its result
  function automatic fb_result_t predict_pack_result(pix_beat_t b);
    fb_result_t res;
    int x, y, addr;
    logic [7:0] mask, v;
    res = '{default: '0};
    if (b.opcode == OP_FLUSH) begin
      // request_full or the post-reset full refresh wins over partial
      if (b.request_full || full_owed) begin
        res.action = ACT_FULL;
        full_owed = 1'b0;
        n_full++;
      end else if (dirty_seen) begin
        res.action = ACT_PARTIAL;
        res.row_first = dirty_lo;
        res.row_last = dirty_hi;
        n_partial++;
      end else begin
        res.action = ACT_NONE;
        n_none++;
      end
      dirty_seen = 1'b0;
      dirty_lo = '0;
      dirty_hi = '0;
      return res;
    end
    x = int'($signed(b.pos_x));
    y = int'($signed(b.pos_y));
    if (x < 0 || y < 0 || x >= FB_COLS || y >= FB_ROWS) begin
      res.action = ACT_DROP;  // off panel: nothing changes
      n_drop++;
      return res;
    end
    addr = y * FB_PITCH + x / 8;
    mask = MSB_MASK >> (x % 8);   // leftmost pixel in the MSB
    v = fb_shadow[addr];
    if (luma_of_565(b.pixel_color) >= int'(thresh_shadow)) v = v | mask;
    else v = v & ~mask;
    fb_shadow[addr] = v;
    if (!dirty_seen) begin
      dirty_seen = 1'b1;
      dirty_lo = 10'(y);
      dirty_hi = 10'(y);
    end else begin
      if (10'(y) < dirty_lo) dirty_lo = 10'(y);
      if (10'(y) > dirty_hi) dirty_hi = 10'(y);
    end
    res.action = ACT_WRITE;
    res.byte_address = 17'(addr);
    res.byte_value = v;
    n_write++;
    return res;
  endfunction

  function automatic pix_beat_t mk_pixel(int x, int y, logic [15:0] color, logic rf);
    pix_beat_t b;
    b.opcode = OP_PIXEL;
    b.pos_x = 16'(x);
    b.pos_y = 16'(y);
    b.pixel_color = color;
    b.request_full = rf;
    return b;
  endfunction

  // Flush with random pixel fields, which the block must ignore
  function automatic pix_beat_t mk_flush(logic rf);
    pix_beat_t b;
    b.opcode = OP_FLUSH;
    b.pos_x = 16'($urandom);
    b.pos_y = 16'($urandom);
    b.pixel_color = 16'($urandom);
    b.request_full = rf;
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // Driving side: one beat per call, starts and returns on a rising edge
  // ---------------------------------------------------------------------
  task automatic send_beat(input pix_beat_t b);
    int gap;
    gap = tx_gap_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= b.opcode;
    in_ch.pos_x        <= b.pos_x;
    in_ch.pos_y        <= b.pos_y;
    in_ch.pixel_color  <= b.pixel_color;
    in_ch.request_full <= b.request_full;
    // Ready is held low during the post-reset clearing pass; just wait it out
    do @(posedge clk); while (!in_ch.ready);
    fb_result_q.push_back(predict_pack_result(b));
    n_beats++;
  endtask

  // Lets every outstanding result come back, then a few quiet cycles
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (fb_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called with the pipeline empty
  task automatic write_threshold(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thresh_shadow = value;
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------
  // Receiving side: random stall before each result beat
  // ---------------------------------------------------------------------
  initial begin : rx_pace
    int stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_stall_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Every result beat is checked against the oldest expectation
  always @(posedge clk) begin : result_check
    fb_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (fb_result_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("%0t: unexpected result beat act=%0d addr=%0d val=%02h rows=%0d..%0d",
                   $realtime, out_ch.action, out_ch.byte_address, out_ch.byte_value,
                   out_ch.row_first, out_ch.row_last);
      end else begin
        want = fb_result_q.pop_front();
        if (out_ch.action !== want.action || out_ch.byte_address !== want.byte_address ||
            out_ch.byte_value !== want.byte_value || out_ch.row_first !== want.row_first ||
            out_ch.row_last !== want.row_last) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $display("%0t: expected act=%0d addr=%0d val=%02h rows=%0d..%0d",
                     $realtime, want.action, want.byte_address, want.byte_value,
                     want.row_first, want.row_last);
            $display("%0t:      got act=%0d addr=%0d val=%02h rows=%0d..%0d",
                     $realtime, out_ch.action, out_ch.byte_address,
                     out_ch.byte_value, out_ch.row_first, out_ch.row_last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset threshold (128), forced first full refresh, then none and partial
  task automatic test_reset_flush();
    send_beat(mk_flush(1'b0));                    // full: owed after reset
    send_beat(mk_flush(1'b0));                    // nothing dirty: none
    send_beat(mk_pixel(5, 3, 16'h0000, 1'b0));    // black clears one bit
    send_beat(mk_pixel(5, 3, 16'hFFFF, 1'b1));    // request_full ignored here
    send_beat(mk_flush(1'b0));                    // partial, rows 3..3
    wait_drained();
  endtask

  // Corners, pure primaries, and coordinates just off each edge
  task automatic test_panel_edges();
    send_beat(mk_pixel(0, 0, 16'h0000, 1'b0));
    send_beat(mk_pixel(FB_COLS - 1, 0, 16'h0000, 1'b0));
    send_beat(mk_pixel(0, FB_ROWS - 1, 16'hF800, 1'b0));
    send_beat(mk_pixel(FB_COLS - 1, FB_ROWS - 1, 16'h07E0, 1'b0));
    send_beat(mk_pixel(FB_COLS / 2, FB_ROWS / 2, 16'h001F, 1'b0));
    send_beat(mk_pixel(-1, 0, 16'h0000, 1'b0));
    send_beat(mk_pixel(0, -1, 16'h0000, 1'b0));
    send_beat(mk_pixel(FB_COLS, 5, 16'h0000, 1'b0));
    send_beat(mk_pixel(5, FB_ROWS, 16'h0000, 1'b0));
    send_beat(mk_pixel(-32768, 32767, 16'h0000, 1'b0));
    send_beat(mk_flush(1'b1));                    // full on request, rows dirty
    wait_drained();
  endtask

  // Threshold extremes; back-to-back hits on one byte exercise forwarding
  task automatic test_threshold_extremes();
    write_threshold(8'd255);                      // only pure white passes
    tx_gap_en = 1'b0;
    rx_stall_en = 1'b0;
    for (int i = 0; i < 8; i++)
      send_beat(mk_pixel(8 + i, 100, (i % 2 == 0) ? 16'h0000 : 16'hFFFF, 1'b0));
    wait_drained();
    write_threshold(8'd0);                        // everything is white
    for (int i = 0; i < 4; i++)
      send_beat(mk_pixel(8 + i, 100, 16'h0000, 1'b0));
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    send_beat(mk_flush(1'b0));
    wait_drained();
  endtask

  function automatic pix_beat_t rand_beat();
    pix_beat_t b;
    int sel, x, y;
    sel = $urandom_range(0, 99);
    b.opcode = OP_PIXEL;
    b.pos_x = 16'($urandom);
    b.pos_y = 16'($urandom);
    b.pixel_color = ($urandom_range(0, 9) == 0) ?
                    ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
    b.request_full = 1'($urandom);
    if (sel < 7) begin
      // flush, mostly without request so partial refreshes show up
      b.opcode = OP_FLUSH;
      b.request_full = ($urandom_range(0, 4) == 0);
    end else if (sel < 11) begin
      // keep the full 16-bit random coordinates: mostly off panel
    end else if (sel < 15) begin
      // just around the panel border
      x = $urandom_range(0, 1) ? FB_COLS - 2 + int'($urandom_range(0, 3))
                                : int'($urandom_range(0, 3)) - 2;
      y = $urandom_range(0, 1) ? FB_ROWS - 2 + int'($urandom_range(0, 3))
                                : int'($urandom_range(0, 3)) - 2;
      b.pos_x = 16'(x);
      b.pos_y = 16'(y);
    end else if (sel < 70) begin
      // hot window: repeated hits on the same few bytes
      b.pos_x = 16'(hot_x + int'($urandom_range(0, HOT_W - 1)));
      b.pos_y = 16'(hot_y + int'($urandom_range(0, HOT_H - 1)));
    end else begin
      b.pos_x = 16'($urandom_range(0, FB_COLS - 1));
      b.pos_y = 16'($urandom_range(0, FB_ROWS - 1));
    end
    return b;
  endfunction

  // Long random stream in phases, with a new threshold between phases
  task automatic test_random_stream();
    logic [7:0] thr;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1:       thr = 8'd0;
        3:       thr = 8'd255;
        default: thr = 8'($urandom_range(0, 255));
      endcase
      write_threshold(thr);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i % 50 == 0) begin
          tx_gap_en = ($urandom_range(0, 2) != 0);
          rx_stall_en = ($urandom_range(0, 2) != 0);
        end
        if (i == 0 || $urandom_range(0, 39) == 0) begin
          hot_x = $urandom_range(0, FB_COLS - HOT_W);
          hot_y = $urandom_range(0, FB_ROWS - HOT_H);
        end
        send_beat(rand_beat());
      end
      wait_drained();
    end
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_PIXEL;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pixel_color  = '0;
    in_ch.request_full = 1'b0;
    reset_shadow();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_flush();
    test_panel_edges();
    test_threshold_extremes();
    test_random_stream();
    wait_drained();

    $display("Covered %0d beats: %0d writes, %0d drops, flushes %0d full/%0d partial/%0d none",
             n_beats, n_write, n_drop, n_full, n_partial, n_none);
    $display("Threshold writes: %0d, result beats checked: %0d, mismatches: %0d",
             n_cfg, n_results, n_bad);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: clearing pass plus the stream, many times over
  initial begin
    #40_000_000;
    $display("Timeout with %0d results still outstanding", fb_result_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rgbmono_pkg.sv
rtl/rgbmono_in_if.sv
rtl/rgbmono_out_if.sv
rtl/rgbmono_ram.sv
rtl/rgbmono_pix_calc.sv
rtl/rgb565_to_mono_framebuffer_packer.sv
rtl/rgbmono_checker.sv
sim/rgb565_to_mono_framebuffer_packer_tb.sv
